// ===== rtl/core/piecewise_linear_curve_table_macros.svh =====
// Assertion macros used by the curve table checker.
`ifndef PIECEWISE_LINEAR_CURVE_TABLE_MACROS_SVH
`define PIECEWISE_LINEAR_CURVE_TABLE_MACROS_SVH

// Same-cycle implication, disabled while reset is active.
`define PLCT_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is active.
`define PLCT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/plct_pkg.sv =====
// Shared types and constants of the piecewise linear curve table.
package plct_pkg;

    // Item field widths.
    localparam int CMD_W   = 2;
    localparam int POS_W   = 8;
    localparam int LEVEL_W = 8;

    // Number of table entries, one per position.
    localparam int TABLE_ENTRIES = 256;

    typedef logic [CMD_W-1:0] cmd_t;

    // Command codes carried on the input tuser.
    localparam cmd_t CMD_CLEAR  = 2'd0;
    localparam cmd_t CMD_ADD    = 2'd1;
    localparam cmd_t CMD_LOOKUP = 2'd2;

endpackage

// ===== rtl/core/piecewise_linear_curve_table.sv =====
// Top level of the piecewise linear curve table.
//
// Input stream (s_axis_*): one item per command. tuser carries the command
// (clear, add breakpoint, look up), tdata carries the position and level.
// Output stream (m_axis_*): one item per lookup, carrying the table entry.
// A lookup is accepted in ST_IDLE, and its result is loaded into the
// output register from ST_LOOK once that register is free; the input is
// not ready in ST_LOOK, and the block takes the next item while the
// result still waits. A clear drops the per-entry valid bits in one step.
// An add writes its own entry and is done when no line fill is due. With
// a fill, one shared adder first runs a restoring division for the slope
// and then steps the accumulator once for each filled position, up to
// 255 positions; s_axis_tready is low meanwhile.
// After reset every entry reads as zero and no breakpoint is remembered.
// When the receiver stalls, a finished lookup result holds in the output
// register and the next lookup waits until that register drains.
module piecewise_linear_curve_table #(
    parameter int FRACTION_BITS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // Bits 7:0 position, bits 15:8 level.
    input  logic [2*plct_pkg::POS_W-1:0]  s_axis_tdata,
    // Bits 1:0 command.
    input  plct_pkg::cmd_t                s_axis_tuser,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // Bits 7:0 mapped_level.
    output logic [plct_pkg::LEVEL_W-1:0]  m_axis_tdata
);

    localparam int POS_W   = plct_pkg::POS_W;
    localparam int LEVEL_W = plct_pkg::LEVEL_W;
    localparam int ENTRIES = plct_pkg::TABLE_ENTRIES;
    // Width of the dividend, quotient and accumulator.
    localparam int DIV_W   = LEVEL_W + FRACTION_BITS;
    localparam int CNT_W   = $clog2(DIV_W + 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOK,
        ST_DIV,
        ST_FILL
    } state_t;

    // Control registers.
    state_t               state_reg, state_next;
    logic                 out_valid_reg, out_valid_next;
    logic [LEVEL_W-1:0]   out_data_reg, out_data_next;
    logic                 have_prev_reg, have_prev_next;
    logic [ENTRIES-1:0]   valid_reg, valid_next;

    // Payload registers.
    logic [POS_W-1:0]     prev_pos_reg, prev_pos_next;
    logic [LEVEL_W-1:0]   prev_lvl_reg, prev_lvl_next;
    logic [POS_W-1:0]     span_reg, span_next;
    logic                 down_reg, down_next;
    logic [DIV_W-1:0]     quo_reg, quo_next;
    logic [POS_W-1:0]     rem_reg, rem_next;
    logic [CNT_W-1:0]     div_cnt_reg, div_cnt_next;
    logic [DIV_W-1:0]     acc_reg, acc_next;
    logic [POS_W-1:0]     fill_pos_reg, fill_pos_next;
    logic [POS_W-1:0]     fill_cnt_reg, fill_cnt_next;
    logic                 rd_valid_reg;
    logic [LEVEL_W-1:0]   rd_data_reg;

    // Table memory.
    logic [LEVEL_W-1:0]   mem [ENTRIES];
    logic                 wr_en;
    logic [POS_W-1:0]     wr_addr;
    logic [LEVEL_W-1:0]   wr_data;
    logic                 rd_en;

    // Input item fields.
    logic                 accept;
    logic [POS_W-1:0]     in_pos;
    logic [LEVEL_W-1:0]   in_lvl;
    logic                 fill_due;
    logic                 in_down;
    logic [LEVEL_W-1:0]   in_rise;

    // Shared adder.
    logic [DIV_W-1:0]     op_a;
    logic [DIV_W-1:0]     op_b;
    logic                 op_sub;
    logic [DIV_W:0]       sum;
    logic                 borrow;
    logic [POS_W:0]       trial;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign in_pos        = s_axis_tdata[POS_W-1:0];
    assign in_lvl        = s_axis_tdata[2*POS_W-1:POS_W];
    assign fill_due      = have_prev_reg && (prev_pos_reg < in_pos);
    assign in_down       = in_lvl < prev_lvl_reg;
    assign in_rise       = in_down ? (prev_lvl_reg - in_lvl) : (in_lvl - prev_lvl_reg);

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    // Partial remainder with the next dividend bit shifted in.
    assign trial = {rem_reg, quo_reg[DIV_W-1]};

    // One adder serves the division steps and the accumulator steps.
    always_comb
    begin
        if (state_reg == ST_DIV)
        begin
            op_a   = DIV_W'(trial);
            op_b   = DIV_W'(span_reg);
            op_sub = 1'b1;
        end
        else
        begin
            op_a   = acc_reg;
            op_b   = quo_reg;
            op_sub = down_reg;
        end
        sum    = op_sub ? ({1'b0, op_a} - {1'b0, op_b}) : ({1'b0, op_a} + {1'b0, op_b});
        borrow = sum[DIV_W];
    end

    // Sequencer and datapath next values.
    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        have_prev_next = have_prev_reg;
        valid_next     = valid_reg;
        prev_pos_next  = prev_pos_reg;
        prev_lvl_next  = prev_lvl_reg;
        span_next      = span_reg;
        down_next      = down_reg;
        quo_next       = quo_reg;
        rem_next       = rem_reg;
        div_cnt_next   = div_cnt_reg;
        acc_next       = acc_reg;
        fill_pos_next  = fill_pos_reg;
        fill_cnt_next  = fill_cnt_reg;
        wr_en          = 1'b0;
        wr_addr        = in_pos;
        wr_data        = in_lvl;
        rd_en          = 1'b0;

        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (s_axis_tuser)
                        plct_pkg::CMD_CLEAR:
                        begin
                            valid_next     = '0;
                            have_prev_next = 1'b0;
                        end
                        plct_pkg::CMD_ADD:
                        begin
                            wr_en          = 1'b1;
                            prev_pos_next  = in_pos;
                            prev_lvl_next  = in_lvl;
                            have_prev_next = 1'b1;
                            if (fill_due)
                            begin
                                span_next     = in_pos - prev_pos_reg;
                                down_next     = in_down;
                                quo_next      = DIV_W'(in_rise) << FRACTION_BITS;
                                rem_next      = '0;
                                div_cnt_next  = CNT_W'(DIV_W);
                                acc_next      = {prev_lvl_reg, FRACTION_BITS'(0)};
                                fill_pos_next = prev_pos_reg;
                                fill_cnt_next = in_pos - prev_pos_reg;
                                state_next    = ST_DIV;
                            end
                        end
                        plct_pkg::CMD_LOOKUP:
                        begin
                            rd_en      = 1'b1;
                            state_next = ST_LOOK;
                        end
                        default:
                        begin
                            // The unused code changes nothing.
                        end
                    endcase
                end
            end
            ST_LOOK:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = rd_valid_reg ? rd_data_reg : '0;
                    state_next     = ST_IDLE;
                end
            end
            ST_DIV:
            begin
                // One quotient bit per cycle, restoring form.
                rem_next     = borrow ? trial[POS_W-1:0] : sum[POS_W-1:0];
                quo_next     = {quo_reg[DIV_W-2:0], ~borrow};
                div_cnt_next = div_cnt_reg - 1'b1;
                if (div_cnt_reg == CNT_W'(1))
                begin
                    state_next = ST_FILL;
                end
            end
            ST_FILL:
            begin
                // Write the truncated accumulator, then step along the line.
                wr_en         = 1'b1;
                wr_addr       = fill_pos_reg;
                wr_data       = acc_reg[DIV_W-1:FRACTION_BITS];
                acc_next      = sum[DIV_W-1:0];
                fill_pos_next = fill_pos_reg + 1'b1;
                fill_cnt_next = fill_cnt_reg - 1'b1;
                if (fill_cnt_reg == POS_W'(1))
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (wr_en)
        begin
            valid_next[wr_addr] = 1'b1;
        end
    end

    // State and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
            have_prev_reg <= 1'b0;
            valid_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            out_data_reg  <= out_data_next;
            have_prev_reg <= have_prev_next;
            valid_reg     <= valid_next;
        end
    end

    // Working registers of the divider and the line fill.
    always_ff @(posedge clk)
    begin
        prev_pos_reg <= prev_pos_next;
        prev_lvl_reg <= prev_lvl_next;
        span_reg     <= span_next;
        down_reg     <= down_next;
        quo_reg      <= quo_next;
        rem_reg      <= rem_next;
        div_cnt_reg  <= div_cnt_next;
        acc_reg      <= acc_next;
        fill_pos_reg <= fill_pos_next;
        fill_cnt_reg <= fill_cnt_next;
        if (rd_en)
        begin
            rd_valid_reg <= valid_reg[in_pos];
        end
    end

    // Table memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[in_pos];
        end
    end

endmodule

// ===== rtl/core/plct_checker.sv =====
// Port-level checker of the piecewise linear curve table, with its bind.
`include "piecewise_linear_curve_table_macros.svh"

module plct_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          s_axis_tvalid,
    input logic                          s_axis_tready,
    input plct_pkg::cmd_t                s_axis_tuser,
    input logic                          m_axis_tvalid,
    input logic                          m_axis_tready,
    input logic [plct_pkg::LEVEL_W-1:0]  m_axis_tdata
);

    logic in_accept;
    logic in_lookup;
    logic in_clear;
    logic in_nonlookup;

    assign in_accept    = s_axis_tvalid && s_axis_tready;
    assign in_lookup    = in_accept && (s_axis_tuser == plct_pkg::CMD_LOOKUP);
    assign in_clear     = in_accept && (s_axis_tuser == plct_pkg::CMD_CLEAR);
    assign in_nonlookup = in_accept && (s_axis_tuser != plct_pkg::CMD_LOOKUP);

    // A stalled result keeps its value.
    `PLCT_ASSERT_NEXT(a_out_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata), "output item changed while stalled")

    // A lookup blocks input while its result is produced.
    `PLCT_ASSERT_NEXT(a_lookup_busy, clk, rst_n, in_lookup, !s_axis_tready,
        "input ready right after a lookup")

    // A clear leaves the input ready.
    `PLCT_ASSERT_NEXT(a_clear_fast, clk, rst_n, in_clear, s_axis_tready,
        "input not ready after a clear")

    // Only a lookup produces a result.
    `PLCT_ASSERT_NEXT(a_no_spurious, clk, rst_n, in_nonlookup, !$rose(m_axis_tvalid),
        "result appeared after a command that makes none")

endmodule

bind piecewise_linear_curve_table plct_checker u_plct_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
